// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SEXPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SEXPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sexpr_pkg.sv =====
// types and constants of the s-expression token scanner
// no dependencies; used by the scanner and its checker
`default_nettype none

package sexpr_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int OFFSET_BITS = 24;
  localparam int LEN_BITS    = 16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [2:0] K_LPAREN = 3'd0;
  localparam logic [2:0] K_RPAREN = 3'd1;
  localparam logic [2:0] K_STRING = 3'd2;
  localparam logic [2:0] K_NUMBER = 3'd3;
  localparam logic [2:0] K_SYMBOL = 3'd4;
  localparam logic [2:0] K_ERROR  = 3'd5;
  localparam logic [2:0] K_EOS    = 3'd6;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
  } scan_in_t;

  typedef struct packed {
    logic [2:0]             token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [COLUMN_BITS-1:0] end_column;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LEN_BITS-1:0]    token_length;
    logic                   last_of_run;
  } token_t;

endpackage

`default_nettype wire

// ===== rtl/sexpr_token_scanner.sv =====
// a byte is registered in the input stage at acceptance and its beats go into the token queue
// throughput: one byte per cycle while byte_stall is low; a byte that yields two tokens
// drains them one per cycle while token_stall is low from a four-entry token queue, and
// the byte side stalls while a byte is staged and at least three beats wait
// reset: synchronous, clears position counters to line 1, column 1, offset 0,
// empties the queue and leaves the scanner idle between tokens
`default_nettype none

module sexpr_token_scanner (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     byte_valid,
  output logic                    byte_stall,
  input  wire sexpr_pkg::scan_in_t byte_item,
  output logic                    token_valid,
  input  wire                     token_stall,
  output sexpr_pkg::token_t       token_item
);
  import sexpr_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_NUMBER  = 3'd3;
  localparam logic [2:0] MODE_SYMBOL  = 3'd4;

  localparam int QDEPTH   = 4;
  localparam int QPTR     = $clog2(QDEPTH);
  localparam int QCNT     = QPTR + 1;
  localparam int SUM_BITS = ((COLUMN_BITS > LEN_BITS) ? COLUMN_BITS : LEN_BITS) + 1;

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
    return (&v) ? v : v + COLUMN_BITS'(1);
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] v);
    return (&v) ? v : v + LEN_BITS'(1);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) ||
           (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return is_blank(b) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_SEMI);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // last column of a pending token, saturating
  function automatic logic [COLUMN_BITS-1:0] end_col(input logic [COLUMN_BITS-1:0] tc,
                                                     input logic [LEN_BITS-1:0] len);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(tc) + SUM_BITS'(len) - SUM_BITS'(1);
    if (s > SUM_BITS'({COLUMN_BITS{1'b1}})) begin
      return {COLUMN_BITS{1'b1}};
    end
    return s[COLUMN_BITS-1:0];
  endfunction

  // scanner state
  logic [2:0]             mode, mode_next;
  logic                   acr, acr_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0] cur_col, cur_col_next;
  logic [OFFSET_BITS-1:0] cur_off, cur_off_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0] tok_col, tok_col_next;
  logic [OFFSET_BITS-1:0] tok_off, tok_off_next;
  logic [LEN_BITS-1:0]    plen, plen_next;

  // input stage
  logic     stage_valid;
  scan_in_t stage_item;
  logic     proc;

  // token queue
  token_t          queue [QDEPTH];
  logic [QPTR-1:0] wr_ptr, rd_ptr;
  logic [QCNT-1:0] count;
  logic            pop;

  logic        emit_a, emit_b, do_idle;
  token_t      res_a, res_b, w0, w1;
  logic [1:0]  nres;
  logic [7:0]  b;

  assign byte_stall  = stage_valid && (count > QCNT'(QDEPTH - 2));
  assign proc        = stage_valid && !byte_stall;
  assign token_valid = (count != '0);
  assign token_item  = queue[rd_ptr];
  assign pop         = token_valid && !token_stall;
  assign b           = stage_item.byte_value;

  always_comb begin
    mode_next     = mode;
    acr_next      = acr;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    cur_off_next  = cur_off;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_off_next  = tok_off;
    plen_next     = plen;
    emit_a        = 1'b0;
    emit_b        = 1'b0;
    do_idle       = 1'b0;
    res_a         = '0;
    res_b         = '0;

    res_a.start_line   = tok_line;
    res_a.start_column = tok_col;
    res_a.start_offset = tok_off;
    res_a.token_length = plen;
    res_a.end_column   = end_col(tok_col, plen);

    if (stage_item.opcode == OP_END) begin
      unique case (mode)
        MODE_NUMBER: begin
          emit_a = 1'b1;
          res_a.token_kind = K_NUMBER;
        end
        MODE_SYMBOL: begin
          emit_a = 1'b1;
          res_a.token_kind = K_SYMBOL;
        end
        MODE_STRING: begin
          emit_a = 1'b1;
          res_a.token_kind = K_ERROR;
        end
        default: ;
      endcase
      emit_b             = 1'b1;
      res_b.token_kind   = K_EOS;
      res_b.start_line   = cur_line;
      res_b.start_column = cur_col;
      res_b.end_column   = cur_col;
      res_b.start_offset = cur_off;
      res_b.token_length = '0;
      mode_next     = MODE_IDLE;
      acr_next      = 1'b0;
      cur_line_next = LINE_BITS'(1);
      cur_col_next  = COLUMN_BITS'(1);
      cur_off_next  = '0;
      tok_line_next = LINE_BITS'(1);
      tok_col_next  = COLUMN_BITS'(1);
      tok_off_next  = '0;
      plen_next     = '0;
    end else begin
      acr_next = 1'b0;
      if (acr && (b == CH_LF)) begin
        cur_col_next = COLUMN_BITS'(1);
        cur_off_next = off_inc(cur_off);
      end else begin
        unique case (mode)
          MODE_COMMENT: begin
            if ((b == CH_CR) || (b == CH_LF)) begin
              do_idle = 1'b1;
            end else begin
              cur_col_next = col_inc(cur_col);
              cur_off_next = off_inc(cur_off);
            end
          end
          MODE_STRING: begin
            cur_col_next = col_inc(cur_col);
            cur_off_next = off_inc(cur_off);
            if (b == CH_QUOTE) begin
              emit_a = 1'b1;
              res_a.token_kind = K_STRING;
              mode_next = MODE_IDLE;
            end else begin
              plen_next = len_inc(plen);
            end
          end
          MODE_NUMBER: begin
            if (is_digit(b) || (b == CH_DOT)) begin
              plen_next    = len_inc(plen);
              cur_col_next = col_inc(cur_col);
              cur_off_next = off_inc(cur_off);
            end else if (!is_sep(b)) begin
              plen_next          = len_inc(plen);
              cur_col_next       = col_inc(cur_col);
              cur_off_next       = off_inc(cur_off);
              emit_a             = 1'b1;
              res_a.token_kind   = K_ERROR;
              res_a.token_length = len_inc(plen);
              res_a.end_column   = end_col(tok_col, len_inc(plen));
              mode_next          = MODE_IDLE;
            end else begin
              emit_a = 1'b1;
              res_a.token_kind = K_NUMBER;
              do_idle = 1'b1;
            end
          end
          MODE_SYMBOL: begin
            if (!is_sep(b)) begin
              plen_next    = len_inc(plen);
              cur_col_next = col_inc(cur_col);
              cur_off_next = off_inc(cur_off);
            end else begin
              emit_a = 1'b1;
              res_a.token_kind = K_SYMBOL;
              do_idle = 1'b1;
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase
      end

      if (do_idle) begin
        mode_next = MODE_IDLE;
        priority if ((b == CH_CR) || (b == CH_LF)) begin
          cur_line_next = line_inc(cur_line);
          cur_col_next  = COLUMN_BITS'(1);
          cur_off_next  = off_inc(cur_off);
          acr_next      = (b == CH_CR);
        end else if (is_blank(b)) begin
          cur_col_next = col_inc(cur_col);
          cur_off_next = off_inc(cur_off);
        end else if ((b == CH_LPAREN) || (b == CH_RPAREN)) begin
          emit_b             = 1'b1;
          res_b.token_kind   = (b == CH_LPAREN) ? K_LPAREN : K_RPAREN;
          res_b.start_line   = cur_line;
          res_b.start_column = cur_col;
          res_b.end_column   = cur_col;
          res_b.start_offset = cur_off;
          res_b.token_length = LEN_BITS'(1);
          cur_col_next       = col_inc(cur_col);
          cur_off_next       = off_inc(cur_off);
        end else if (b == CH_SEMI) begin
          mode_next    = MODE_COMMENT;
          cur_col_next = col_inc(cur_col);
          cur_off_next = off_inc(cur_off);
        end else if (b == CH_QUOTE) begin
          cur_col_next  = col_inc(cur_col);
          cur_off_next  = off_inc(cur_off);
          tok_line_next = cur_line;
          tok_col_next  = col_inc(cur_col);
          tok_off_next  = off_inc(cur_off);
          plen_next     = '0;
          mode_next     = MODE_STRING;
        end else begin
          tok_line_next = cur_line;
          tok_col_next  = cur_col;
          tok_off_next  = cur_off;
          plen_next     = LEN_BITS'(1);
          mode_next     = is_digit(b) ? MODE_NUMBER : MODE_SYMBOL;
          cur_col_next  = col_inc(cur_col);
          cur_off_next  = off_inc(cur_off);
        end
      end
    end

    // pack the beats in order, last flag on the final one
    w0 = emit_a ? res_a : res_b;
    w0.last_of_run = !(emit_a && emit_b);
    w1 = res_b;
    w1.last_of_run = 1'b1;
    nres = {1'b0, emit_a} + {1'b0, emit_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!byte_stall) begin
      stage_valid <= byte_valid;
    end
    if (!byte_stall && byte_valid) begin
      stage_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      acr      <= 1'b0;
      cur_line <= LINE_BITS'(1);
      cur_col  <= COLUMN_BITS'(1);
      cur_off  <= '0;
      tok_line <= LINE_BITS'(1);
      tok_col  <= COLUMN_BITS'(1);
      tok_off  <= '0;
      plen     <= '0;
    end else if (proc) begin
      mode     <= mode_next;
      acr      <= acr_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      cur_off  <= cur_off_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_off  <= tok_off_next;
      plen     <= plen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (nres != 2'd0)) begin
      queue[wr_ptr] <= w0;
    end
    if (proc && (nres == 2'd2)) begin
      queue[wr_ptr + QPTR'(1)] <= w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (proc) begin
        wr_ptr <= wr_ptr + QPTR'(nres);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR'(1);
      end
      count <= count + (proc ? QCNT'(nres) : QCNT'(0)) - QCNT'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sexpr_checker.sv =====
// port-level checks of the s-expression token scanner, bound into every scanner instance
// depends on sexpr_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module sexpr_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      byte_valid,
  input wire                      byte_stall,
  input wire sexpr_pkg::scan_in_t byte_item,
  input wire                      token_valid,
  input wire                      token_stall,
  input wire sexpr_pkg::token_t   token_item
);
  import sexpr_pkg::*;

  logic byte_wait, token_wait;
  logic eos_beat, eos_ok, paren_beat, paren_ok;

  assign byte_wait  = byte_valid && byte_stall;
  assign token_wait = token_valid && token_stall;
  assign eos_beat   = token_valid && (token_item.token_kind == K_EOS);
  assign eos_ok     = (token_item.token_length == '0) &&
                      (token_item.end_column == token_item.start_column) &&
                      token_item.last_of_run;
  assign paren_beat = token_valid && ((token_item.token_kind == K_LPAREN) ||
                                      (token_item.token_kind == K_RPAREN));
  assign paren_ok   = (token_item.token_length == LEN_BITS'(1)) &&
                      (token_item.end_column == token_item.start_column) &&
                      token_item.last_of_run;

  `SEXPR_ASSERT_NEXT(a_byte_hold, byte_wait, byte_valid && $stable(byte_item), "byte beat moved")
  `SEXPR_ASSERT_NEXT(a_tok_hold, token_wait, token_valid && $stable(token_item), "token moved")
  `SEXPR_ASSERT_NOW(a_eos_shape, eos_beat, eos_ok, "end of stream beat malformed")
  `SEXPR_ASSERT_NOW(a_paren_shape, paren_beat, paren_ok, "paren beat malformed")
  `SEXPR_ASSERT_NOW(a_stall_backlog, byte_stall, token_valid, "byte stall with no token pending")

endmodule

bind sexpr_token_scanner sexpr_checker u_sexpr_checker (.*);

`default_nettype wire
